// ----- rtl/core/arenv_pkg.sv -----
`default_nettype none

package arenv_pkg;

  // detect_mode codes
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_SQUARE = 2'd1;
  localparam logic [1:0] MODE_ABS    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DETECT_MODE  = 2'd0;
  localparam logic [1:0] CFG_ATTACK_COEF  = 2'd1;
  localparam logic [1:0] CFG_RELEASE_COEF = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_NORM,
    ST_DIFF,
    ST_SCALE,
    ST_SUM
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/attack_release_envelope_detector.sv -----
// Attack/release envelope detector.
// Input channel (in_valid/in_ready): one signed sample and a hold flag per
// transaction. Output channel (out_valid/out_ready): one envelope per input.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 detect_mode,
// 1 attack_coef, 2 release_coef; other indexes are ignored. Write config
// only while the block is idle.
// Every item without hold runs through one shared signed multiplier
// under a small sequencer: an optional squaring pass, then the
// coefficient product. A held item goes straight to the sum step; pass
// and absolute value run difference, scale and sum; square first runs
// square and normalize.
// in_ready is high only while the sequencer is idle. A finished result
// sits in the output register while the next item is accepted and
// processed; the sequencer waits in its last step only if the output
// register is still full when the next result is ready.
// Reset (synchronous, active low) clears the envelope, all config
// registers and the output valid flag; the output data is not reset.
`default_nettype none

module attack_release_envelope_detector #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire signed [SAMPLE_WIDTH-1:0] in_sample,
  input  wire                           in_hold,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [SAMPLE_WIDTH:0]  out_envelope,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire        [1:0]              cfg_index,
  input  wire        [COEF_WIDTH-1:0]   cfg_data
);

  localparam int XW = SAMPLE_WIDTH + 1;   // detected value / envelope
  localparam int DW = SAMPLE_WIDTH + 2;   // difference
  localparam int MW = (DW > COEF_WIDTH + 1) ? DW : COEF_WIDTH + 1;
  localparam int PW = 2 * MW;

  arenv_pkg::state_t state_r, state_nxt;

  logic [1:0]            mode_r;
  logic [COEF_WIDTH-1:0] attack_r, release_r, coef_r;
  logic signed [XW-1:0]  x_r, last_r, env;
  logic signed [DW-1:0]  d_r;
  logic signed [PW-1:0]  prod_r, prod_sh;
  logic                  hold_r;
  logic                  out_valid_r;
  logic signed [XW-1:0]  out_env_r;

  logic signed [XW-1:0]  sx, absx, x_in;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  mul_p;
  logic                  accept, out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_envelope = out_env_r;

  // front end
  assign sx   = XW'(in_sample);
  assign absx = sx[XW-1] ? -sx : sx;

  always_comb begin
    unique case (mode_r)
      arenv_pkg::MODE_SQUARE: x_in = absx;  // magnitude, squared later
      arenv_pkg::MODE_ABS:    x_in = absx;
      default:                x_in = sx;
    endcase
  end

  // shared multiplier
  always_comb begin
    if (state_r == arenv_pkg::ST_SQUARE) begin
      mul_a = MW'(x_r);
      mul_b = MW'(x_r);
    end else begin
      mul_a = MW'(d_r);
      mul_b = MW'({1'b0, coef_r});
    end
  end

  assign mul_p   = PW'(mul_a) * PW'(mul_b);
  assign prod_sh = prod_r >>> COEF_WIDTH;
  assign env     = hold_r ? last_r : x_r + XW'(prod_sh);

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      arenv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_hold)
            state_nxt = arenv_pkg::ST_SUM;
          else if (mode_r == arenv_pkg::MODE_SQUARE)
            state_nxt = arenv_pkg::ST_SQUARE;
          else
            state_nxt = arenv_pkg::ST_DIFF;
        end
      end
      arenv_pkg::ST_SQUARE: state_nxt = arenv_pkg::ST_NORM;
      arenv_pkg::ST_NORM:   state_nxt = arenv_pkg::ST_DIFF;
      arenv_pkg::ST_DIFF:   state_nxt = arenv_pkg::ST_SCALE;
      arenv_pkg::ST_SCALE:  state_nxt = arenv_pkg::ST_SUM;
      arenv_pkg::ST_SUM: begin
        if (out_free)
          state_nxt = arenv_pkg::ST_IDLE;
      end
      default: state_nxt = arenv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arenv_pkg::ST_IDLE;
      mode_r      <= '0;
      attack_r    <= '0;
      release_r   <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        unique case (cfg_index)
          arenv_pkg::CFG_DETECT_MODE:  mode_r    <= cfg_data[1:0];
          arenv_pkg::CFG_ATTACK_COEF:  attack_r  <= cfg_data;
          arenv_pkg::CFG_RELEASE_COEF: release_r <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == arenv_pkg::ST_SUM && out_free) begin
        last_r      <= env;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= x_in;
      hold_r <= in_hold;
    end
    unique case (state_r)
      arenv_pkg::ST_SQUARE: prod_r <= mul_p;
      arenv_pkg::ST_NORM:   x_r    <= prod_r[SAMPLE_WIDTH-1 +: XW];
      arenv_pkg::ST_DIFF: begin
        d_r    <= DW'(last_r) - DW'(x_r);
        coef_r <= (x_r > last_r) ? attack_r : release_r;
      end
      arenv_pkg::ST_SCALE:  prod_r <= mul_p;
      default: ;
    endcase
    if (state_r == arenv_pkg::ST_SUM && out_free)
      out_env_r <= env;
  end

endmodule

`default_nettype wire

// ----- rtl/core/arenv_checker.sv -----
`default_nettype none

module arenv_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire signed [SAMPLE_WIDTH:0]  out_envelope
);

  localparam logic signed [SAMPLE_WIDTH:0] ENV_MAX =
    (SAMPLE_WIDTH + 1)'(1) <<< (SAMPLE_WIDTH - 1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_envelope))
    else $error("output changed while stalled");

  // one item at a time: no accept right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // envelope stays within the Q1.x range, +1.0 included
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_envelope[SAMPLE_WIDTH] == out_envelope[SAMPLE_WIDTH-1]) ||
                  (out_envelope == ENV_MAX))
    else $error("envelope out of range");

endmodule

bind attack_release_envelope_detector arenv_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_arenv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_envelope (out_envelope)
);

`default_nettype wire

// ----- verif/attack_release_envelope_detector_test.sv -----
`timescale 1ns / 100ps

module attack_release_envelope_detector_test;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 130;
  localparam int RANDOM_PHASES = 12;

  // mode 3 is undefined and behaves as pass-through; index 3 is not a register
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // sender/receiver idle profiles
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SENDER = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic hold;
  } sample_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic in_hold = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W:0] out_envelope;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // predictor state and its copy of the registers
  logic signed [SAMPLE_W:0] env_state = '0;
  logic [1:0] mode_reg = arenv_pkg::MODE_PASS;
  logic [COEF_W-1:0] attack_reg = '0;
  logic [COEF_W-1:0] release_reg = '0;

  sample_item_t sample_q[$];
  logic signed [SAMPLE_W:0] env_expect_q[$];
  sample_item_t drive_item;
  logic signed [SAMPLE_W:0] env_expected;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int idle_cycles = 0;

  attack_release_envelope_detector #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .COEF_WIDTH(COEF_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample(in_sample),
    .in_hold(in_hold),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_envelope(out_envelope),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [SAMPLE_W:0] follow_envelope(
    input logic signed [SAMPLE_W-1:0] sample,
    input logic hold
  );
    logic signed [47:0] x;
    logic signed [47:0] coef;
    logic signed [47:0] gap;
    logic signed [47:0] prod;
    logic signed [47:0] sum;
    if (hold) begin
      return env_state;
    end
    x = 48'(sample);
    case (mode_reg)
      arenv_pkg::MODE_SQUARE: x = (x * x) >>> (SAMPLE_W - 1);
      arenv_pkg::MODE_ABS: if (x < 0) x = -x;
      default: ;
    endcase
    coef = (x > env_state) ? 48'(attack_reg) : 48'(release_reg);
    gap = 48'(env_state) - x;
    prod = coef * gap;
    // arithmetic shift floors toward minus infinity
    sum = x + (prod >>> COEF_W);
    env_state = sum[SAMPLE_W:0];
    return env_state;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        env_expect_q.push_back(follow_envelope(in_sample, in_hold));
      end
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          drive_item = sample_q.pop_front();
          in_valid <= 1'b1;
          in_sample <= drive_item.sample;
          in_hold <= drive_item.hold;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (env_expect_q.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected envelope %0d with nothing pending", out_envelope);
        end
        fail_count++;
      end else begin
        env_expected = env_expect_q.pop_front();
        if (out_envelope !== env_expected) begin
          if (fail_count < 10) begin
            $display("envelope mismatch: expected %0d, got %0d", env_expected,
                     out_envelope);
          end
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles without any transaction on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  task automatic drain();
    do begin
      @(negedge clk);
    end while (sample_q.size() != 0 || in_valid || env_expect_q.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [COEF_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (index)
      arenv_pkg::CFG_DETECT_MODE: mode_reg = data[1:0];
      arenv_pkg::CFG_ATTACK_COEF: attack_reg = data;
      arenv_pkg::CFG_RELEASE_COEF: release_reg = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(
    input logic [1:0] mode,
    input logic [COEF_W-1:0] attack,
    input logic [COEF_W-1:0] release_c
  );
    logic [COEF_W-1:0] mode_word;
    drain();
    mode_word = COEF_W'($urandom);
    mode_word[1:0] = mode;
    write_reg(arenv_pkg::CFG_DETECT_MODE, mode_word);
    write_reg(arenv_pkg::CFG_ATTACK_COEF, attack);
    write_reg(arenv_pkg::CFG_RELEASE_COEF, release_c);
    @(negedge clk);
  endtask

  task automatic set_idle(input int profile);
    case (profile)
      IDLE_SENDER: begin
        sender_idle_pct = 69;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;
        recv_stall_pct = 69;
      end
      IDLE_BOTH: begin
        sender_idle_pct = 8;
        recv_stall_pct = 8;
      end
      default: begin
        sender_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic send(input logic signed [SAMPLE_W-1:0] sample, input logic hold);
    sample_item_t item;
    item.sample = sample;
    item.hold = hold;
    sample_q.push_back(item);
  endtask

  task automatic send_random();
    logic signed [SAMPLE_W-1:0] sample;
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) begin
      sample = SAMPLE_W'($urandom);
    end else if (pick < 7) begin
      case ($urandom_range(3))
        0: sample = -16'sd32768;
        1: sample = 16'sd32767;
        2: sample = 16'sd0;
        default: sample = -16'sd1;
      endcase
    end else begin
      // quiet passages, so slow release tails get exercised
      sample = $signed(16'($urandom_range(511))) - 16'sd256;
    end
    send(sample, $urandom_range(7) == 0);
  endtask

  initial begin
    logic [COEF_W-1:0] attack;
    logic [COEF_W-1:0] release_c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: hold right after reset, extremes per mode
    configure(arenv_pkg::MODE_PASS, 16'h8000, 16'hC000);
    send(16'sd0, 1'b1);
    send(16'sd32767, 1'b0);
    send(-16'sd32768, 1'b0);
    send(16'sd0, 1'b0);
    send(16'sd1, 1'b0);
    send(-16'sd1, 1'b0);

    configure(arenv_pkg::MODE_SQUARE, 16'h0000, 16'hFFFF);
    send(-16'sd32768, 1'b0);
    send(16'sd32767, 1'b0);
    send(-16'sd1, 1'b0);
    send(16'sd5, 1'b1);

    configure(arenv_pkg::MODE_ABS, 16'hFFFF, 16'h0000);
    send(-16'sd32768, 1'b0);
    send(16'sd32767, 1'b0);
    send(16'sd0, 1'b0);
    send(-16'sd7, 1'b1);

    configure(MODE_UNUSED, 16'h4000, 16'h4000);
    send(-16'sd32768, 1'b0);
    send(16'sd32767, 1'b0);
    send(16'sd5, 1'b0);

    // write to a nonexistent register must leave everything alone
    drain();
    write_reg(CFG_UNUSED, 16'hFFFF);
    @(negedge clk);
    send(-16'sd20000, 1'b0);
    send(16'sd12345, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin attack = 16'h0000; release_c = 16'h0000; end
        1: begin attack = 16'hFFFF; release_c = 16'hFFFF; end
        2: begin attack = 16'h0000; release_c = 16'hFFFF; end
        3: begin attack = 16'hFFFF; release_c = 16'h0000; end
        default: begin
          attack = COEF_W'($urandom);
          release_c = COEF_W'($urandom);
        end
      endcase
      configure(2'(p % 4), attack, release_c);
      if (p % 5 == 4) begin
        write_reg(CFG_UNUSED, COEF_W'($urandom));
        @(negedge clk);
      end
      set_idle((p / 4 + p) % 4);
      repeat (PHASE_ITEMS) send_random();
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && env_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
